// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, off while in reset.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/bts_pkg.sv -----
package bts_pkg;

  localparam int unsigned CHANNEL_BITS  = 16;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned STORE_DEPTH_DEF = 65536;
  localparam int unsigned NUM_CH = 3;

  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned SIZE_BITS  = 13;
  localparam int unsigned IDX_BITS   = SIZE_BITS;
  localparam int unsigned P_BITS     = FRACTION_BITS + SIZE_BITS + 2;
  localparam int unsigned X_BITS     = P_BITS - FRACTION_BITS;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_LAYERS = 3'd2,
    REG_WRAP_U = 3'd3,
    REG_WRAP_V = 3'd4,
    REG_NCH    = 3'd5
  } reg_idx_e;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef logic [NUM_CH-1:0][CHANNEL_BITS-1:0] texel_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] i0;
    logic [IDX_BITS-1:0] i1;
  } axis_t;

  function automatic logic [CHANNEL_BITS-1:0] lerp(
    input logic [CHANNEL_BITS-1:0] lo,
    input logic [CHANNEL_BITS-1:0] hi,
    input logic [FRACTION_BITS-1:0] s
  );
    logic [FRACTION_BITS:0] ws;
    logic [FRACTION_BITS:0] wl;
    logic [CHANNEL_BITS+FRACTION_BITS+1:0] acc;
    ws = {1'b0, s};
    wl = (FRACTION_BITS+1)'(1) << FRACTION_BITS;
    wl = wl - ws;
    acc = (CHANNEL_BITS+FRACTION_BITS+2)'(lo * wl) + (CHANNEL_BITS+FRACTION_BITS+2)'(hi * ws)
        + ((CHANNEL_BITS+FRACTION_BITS+2)'(1) << (FRACTION_BITS-1));
    return acc[FRACTION_BITS +: CHANNEL_BITS];
  endfunction

endpackage

// ----- hdl/bilinear_texture_sampler_2d.sv -----
// channel | handshake                | payload
// in      | in_valid_i / in_ready_o  | opcode_i, coord_u_i, coord_v_i, layer_i,
//         |                          | texel_index_i, texel_ch0_i..texel_ch2_i
// out     | out_valid_o / out_ready_i| sample_ch0_o..sample_ch2_o
// cfg     | cfg_we_i                 | cfg_index_i, cfg_data_i
// A write beat is stored without leaving idle. A sample beat runs coordinate
// scaling, edge split, row address math, four reads from the single-port
// texel memory, then the u and v blends. A new beat is taken in the cycle
// after the result enters the output register; a stalled result holds the
// sequencer. Reset clears control, presets config; texel memory is not cleared.
module bilinear_texture_sampler_2d #(
  parameter int unsigned STORE_DEPTH = bts_pkg::STORE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_index_i,
  input  logic [bts_pkg::SIZE_BITS-1:0]    cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             opcode_i,
  input  logic signed [23:0]               coord_u_i,
  input  logic signed [23:0]               coord_v_i,
  input  logic [7:0]                       layer_i,
  input  logic [15:0]                      texel_index_i,
  input  logic [bts_pkg::CHANNEL_BITS-1:0] texel_ch0_i,
  input  logic [bts_pkg::CHANNEL_BITS-1:0] texel_ch1_i,
  input  logic [bts_pkg::CHANNEL_BITS-1:0] texel_ch2_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bts_pkg::CHANNEL_BITS-1:0] sample_ch0_o,
  output logic [bts_pkg::CHANNEL_BITS-1:0] sample_ch1_o,
  output logic [bts_pkg::CHANNEL_BITS-1:0] sample_ch2_o
);
  import bts_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCALE, S_SPLIT, S_ROW, S_RD0, S_RD1, S_RD2, S_RD3, S_BOT, S_VL, S_OUT
  } state_e;

  state_e state_q;

  logic [SIZE_BITS-1:0] width_q, height_q;
  logic [8:0]           layers_q;
  logic                 wrap_u_q, wrap_v_q;
  logic [1:0]           nch_q;

  logic signed [COORD_BITS-1:0] cu_q, cv_q;
  logic [7:0]                   lay_q;
  logic signed [P_BITS-1:0]     pu_q, pv_q;
  logic [FRACTION_BITS-1:0]     s_q, t_q;
  axis_t                        ax_q, ay_q;
  logic [20:0]                  base_q;
  logic [AW-1:0]                row0_q, row1_q;
  texel_t                       t00_q, t01_q, t10_q, top_q, bot_q, res_q;
  texel_t                       rd_q;
  logic                         out_valid_q;
  texel_t                       out_q;

  texel_t mem [STORE_DEPTH];

  logic [SIZE_BITS-1:0] w_eff, h_eff;
  logic [8:0]           cnt_eff;
  logic [1:0]           nch_eff;
  logic [AW-1:0]        mem_addr;
  logic                 mem_we;
  logic                 in_acc;

  assign w_eff   = (width_q == '0) ? SIZE_BITS'(1) : width_q;
  assign h_eff   = (height_q == '0) ? SIZE_BITS'(1) : height_q;
  assign cnt_eff = (layers_q == '0) ? 9'd1 : layers_q;
  assign nch_eff = (nch_q == '0) ? 2'd1 : nch_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign mem_we     = in_acc && (opcode_i == OP_WRITE);

  function automatic logic signed [P_BITS-1:0] scale_p(
    input logic signed [COORD_BITS-1:0] c,
    input logic [SIZE_BITS-1:0] size,
    input logic rep
  );
    logic [FRACTION_BITS:0] a;
    logic [FRACTION_BITS+SIZE_BITS:0] prod;
    if (rep) begin
      a = {1'b0, c[FRACTION_BITS-1:0]};
    end else if (c < 0) begin
      a = '0;
    end else if (c > $signed(COORD_BITS'(1) << FRACTION_BITS)) begin
      a = (FRACTION_BITS+1)'(1) << FRACTION_BITS;
    end else begin
      a = c[FRACTION_BITS:0];
    end
    prod = a * size;
    return $signed({1'b0, prod}) - $signed(P_BITS'(1) << (FRACTION_BITS-1));
  endfunction

  function automatic axis_t edges(
    input logic signed [X_BITS-1:0] x,
    input logic [SIZE_BITS-1:0] size,
    input logic rep
  );
    axis_t r;
    logic signed [X_BITS-1:0] b;
    logic signed [X_BITS-1:0] x1;
    b  = $signed(X_BITS'(size - SIZE_BITS'(1)));
    x1 = x + X_BITS'(1);
    if (rep) begin
      r.i0 = (x < 0 || x > b) ? IDX_BITS'(b) : IDX_BITS'(x);
      r.i1 = (x >= b) ? '0 : IDX_BITS'(x1);
    end else begin
      r.i0 = (x < 0) ? '0 : ((x > b) ? IDX_BITS'(b) : IDX_BITS'(x));
      r.i1 = (x1 > b) ? IDX_BITS'(b) : ((x1 < 0) ? '0 : IDX_BITS'(x1));
    end
    return r;
  endfunction

  always_comb begin
    logic [31:0] sum;
    sum = 32'(texel_index_i);
    case (state_q)
      S_RD0:   sum = 32'(row0_q) + 32'(ax_q.i0);
      S_RD1:   sum = 32'(row0_q) + 32'(ax_q.i1);
      S_RD2:   sum = 32'(row1_q) + 32'(ax_q.i0);
      S_RD3:   sum = 32'(row1_q) + 32'(ax_q.i1);
      default: sum = 32'(texel_index_i);
    endcase
    mem_addr = sum[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= {texel_ch2_i, texel_ch1_i, texel_ch0_i};
    end
    rd_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_BITS'(1);
      height_q <= SIZE_BITS'(1);
      layers_q <= 9'd1;
      wrap_u_q <= 1'b0;
      wrap_v_q <= 1'b0;
      nch_q    <= 2'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_LAYERS: layers_q <= cfg_data_i[8:0];
        REG_WRAP_U: wrap_u_q <= cfg_data_i[0];
        REG_WRAP_V: wrap_v_q <= cfg_data_i[0];
        REG_NCH:    nch_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && opcode_i == OP_SAMPLE) begin
            state_q <= S_SCALE;
          end
        end
        S_SCALE: state_q <= S_SPLIT;
        S_SPLIT: state_q <= S_ROW;
        S_ROW:   state_q <= S_RD0;
        S_RD0:   state_q <= S_RD1;
        S_RD1:   state_q <= S_RD2;
        S_RD2:   state_q <= S_RD3;
        S_RD3:   state_q <= S_BOT;
        S_BOT:   state_q <= S_VL;
        S_VL:    state_q <= S_OUT;
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    logic [8:0] lmax;
    logic [21:0] r0, r1;
    lmax = cnt_eff - 9'd1;
    case (state_q)
      S_IDLE: begin
        cu_q  <= coord_u_i;
        cv_q  <= coord_v_i;
        lay_q <= layer_i;
      end
      S_SCALE: begin
        pu_q  <= scale_p(cu_q, w_eff, wrap_u_q);
        pv_q  <= scale_p(cv_q, h_eff, wrap_v_q);
        lay_q <= ({1'b0, lay_q} > lmax) ? lmax[7:0] : lay_q;
      end
      S_SPLIT: begin
        ax_q   <= edges(pu_q[P_BITS-1:FRACTION_BITS], w_eff, wrap_u_q);
        ay_q   <= edges(pv_q[P_BITS-1:FRACTION_BITS], h_eff, wrap_v_q);
        s_q    <= pu_q[FRACTION_BITS-1:0];
        t_q    <= pv_q[FRACTION_BITS-1:0];
        base_q <= 21'(lay_q * h_eff);
      end
      S_ROW: begin
        r0 = 22'(base_q) + 22'(ay_q.i0);
        r1 = 22'(base_q) + 22'(ay_q.i1);
        row0_q <= AW'(r0 * w_eff);
        row1_q <= AW'(r1 * w_eff);
      end
      S_RD1: t00_q <= rd_q;
      S_RD2: t01_q <= rd_q;
      S_RD3: begin
        t10_q <= rd_q;
        for (int c = 0; c < NUM_CH; c++) begin
          top_q[c] <= lerp(t00_q[c], t01_q[c], s_q);
        end
      end
      S_BOT: begin
        for (int c = 0; c < NUM_CH; c++) begin
          bot_q[c] <= lerp(t10_q[c], rd_q[c], s_q);
        end
      end
      S_VL: begin
        for (int c = 0; c < NUM_CH; c++) begin
          res_q[c] <= (2'(c) < nch_eff) ? lerp(top_q[c], bot_q[c], t_q) : '0;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_q <= res_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign sample_ch0_o = out_q[0];
  assign sample_ch1_o = out_q[1];
  assign sample_ch2_o = out_q[2];

  `ASSERT_NEXT(a_samp_start, in_valid_i && in_ready_o && opcode_i == OP_SAMPLE, state_q == S_SCALE)
  `ASSERT_NEXT(a_rd_seq, state_q == S_RD0, state_q == S_RD1 && !in_ready_o)
  `ASSERT_NEXT(a_out_hold, state_q == S_OUT && out_valid_q && !out_ready_i, state_q == S_OUT)

endmodule
